FILE: hdl/sstsum_pkg.sv
// ----------------------------------------------------------------------------
// sstsum_pkg
// Shared constants, types and the range-split helper of the sparse segment
// tree sum block.
// ----------------------------------------------------------------------------
`default_nettype none

package sstsum_pkg;

    localparam int DefIndexBits = 32;
    localparam int DefNodeCount = 4096;
    localparam int DefValueBits = 64;

    // Node ranges [l, l + w) never exceed 2^33 - 1.
    localparam int SpanBits   = 33;
    // Path stack: one entry per inner node of a root-to-leaf path.
    localparam int StackDepth = 34;
    localparam int SpBits     = 6;

    localparam logic [1:0] FuncSet   = 2'd0;
    localparam logic [1:0] FuncAdd   = 2'd1;
    localparam logic [1:0] FuncQuery = 2'd2;

    localparam logic [1:0] StatOk    = 2'd0;
    localparam logic [1:0] StatFull  = 2'd1;
    localparam logic [1:0] StatRange = 2'd2;

    typedef struct packed {
        logic sum;
        logic left;
        logic right;
    } t_wr_en;

    typedef struct packed {
        logic [SpanBits-1:0] mid;
        logic [SpanBits-1:0] lo_span;
        logic [SpanBits-1:0] hi_span;
    } t_split;

    // Halve the range [l, l + w) at l + w/2.
    function automatic t_split split_span(input logic [SpanBits-1:0] l,
                                          input logic [SpanBits-1:0] w);
        t_split s;
        s.mid     = l + (w >> 1);
        s.lo_span = w >> 1;
        s.hi_span = w - (w >> 1);
        return s;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/sstsum_mem.sv
// ----------------------------------------------------------------------------
// sstsum_mem
// Node pool: sum and both child links per node, one write port and one
// registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module sstsum_mem #(
    parameter int NODE_COUNT = sstsum_pkg::DefNodeCount,
    parameter int VALUE_BITS = sstsum_pkg::DefValueBits,
    localparam int AW = $clog2(NODE_COUNT),
    localparam int NW = $clog2(NODE_COUNT + 1)
) (
    input  logic                   i_clk,
    input  logic                   i_rd_en,
    input  logic [AW-1:0]          i_rd_addr,
    output logic [VALUE_BITS-1:0]  o_rd_sum,
    output logic [NW-1:0]          o_rd_left,
    output logic [NW-1:0]          o_rd_right,
    input  sstsum_pkg::t_wr_en     i_wr_en,
    input  logic [AW-1:0]          i_wr_addr,
    input  logic [VALUE_BITS-1:0]  i_wr_sum,
    input  logic [NW-1:0]          i_wr_left,
    input  logic [NW-1:0]          i_wr_right
);
    import sstsum_pkg::*;

    logic [VALUE_BITS-1:0] r_sum_mem   [NODE_COUNT];
    logic [NW-1:0]         r_left_mem  [NODE_COUNT];
    logic [NW-1:0]         r_right_mem [NODE_COUNT];
    logic [VALUE_BITS-1:0] r_rd_sum;
    logic [NW-1:0]         r_rd_left;
    logic [NW-1:0]         r_rd_right;

    always_ff @(posedge i_clk) begin
        if (i_wr_en.sum) begin
            r_sum_mem[i_wr_addr] <= i_wr_sum;
        end
        if (i_wr_en.left) begin
            r_left_mem[i_wr_addr] <= i_wr_left;
        end
        if (i_wr_en.right) begin
            r_right_mem[i_wr_addr] <= i_wr_right;
        end
        if (i_rd_en) begin
            r_rd_sum   <= r_sum_mem[i_rd_addr];
            r_rd_left  <= r_left_mem[i_rd_addr];
            r_rd_right <= r_right_mem[i_rd_addr];
        end
    end

    assign o_rd_sum   = r_rd_sum;
    assign o_rd_left  = r_rd_left;
    assign o_rd_right = r_rd_right;

endmodule

`default_nettype wire

FILE: hdl/sstsum_core.sv
// ----------------------------------------------------------------------------
// sstsum_core
// Sequencer that walks the tree one level at a time through the shared
// range-split adder: point writes with lazy allocation, range sum queries.
// ----------------------------------------------------------------------------
`default_nettype none

module sstsum_core #(
    parameter int NODE_COUNT = sstsum_pkg::DefNodeCount,
    parameter int VALUE_BITS = sstsum_pkg::DefValueBits,
    localparam int AW = $clog2(NODE_COUNT),
    localparam int NW = $clog2(NODE_COUNT + 1)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [1:0]             i_func,
    input  logic [31:0]            i_key,
    input  logic [32:0]            i_hi,
    input  logic [VALUE_BITS-1:0]  i_x,
    input  logic [32:0]            i_dom,
    input  logic                   i_take,
    output logic                   o_idle,
    output logic                   o_done,
    output logic [VALUE_BITS-1:0]  o_result,
    output logic [1:0]             o_status,
    output logic                   o_rd_en,
    output logic [AW-1:0]          o_rd_addr,
    input  logic [VALUE_BITS-1:0]  i_rd_sum,
    input  logic [NW-1:0]          i_rd_left,
    input  logic [NW-1:0]          i_rd_right,
    output sstsum_pkg::t_wr_en     o_wr_en,
    output logic [AW-1:0]          o_wr_addr,
    output logic [VALUE_BITS-1:0]  o_wr_sum,
    output logic [NW-1:0]          o_wr_left,
    output logic [NW-1:0]          o_wr_right
);
    import sstsum_pkg::*;

    localparam logic [NW-1:0] Null = NW'(NODE_COUNT);
    localparam int            EW   = AW + NW;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_WNODE   = 4'd1;
    localparam logic [3:0] S_WLINK   = 4'd2;
    localparam logic [3:0] S_WCOUNT  = 4'd3;
    localparam logic [3:0] S_WATTACH = 4'd4;
    localparam logic [3:0] S_WALLOC  = 4'd5;
    localparam logic [3:0] S_WPOP    = 4'd6;
    localparam logic [3:0] S_WSIB    = 4'd7;
    localparam logic [3:0] S_WUP     = 4'd8;
    localparam logic [3:0] S_QNODE   = 4'd9;
    localparam logic [3:0] S_QEVAL   = 4'd10;
    localparam logic [3:0] S_QSIB    = 4'd11;
    localparam logic [3:0] S_QSADD   = 4'd12;
    localparam logic [3:0] S_DONE    = 4'd13;

    localparam logic [1:0] SideCommon = 2'd0;
    localparam logic [1:0] SideLeft   = 2'd1;
    localparam logic [1:0] SideRight  = 2'd2;

    logic [3:0]            r_state, n_state;
    logic [SpanBits-1:0]   r_l, n_l, r_w, n_w;
    logic [SpanBits-1:0]   r_save_l, n_save_l, r_save_w, n_save_w;
    logic [SpanBits-1:0]   r_pl, n_pl, r_pw, n_pw;
    logic [NW-1:0]         r_cur, n_cur, r_used, n_used, r_root, n_root;
    logic [NW-1:0]         r_pend, n_pend, r_sib, n_sib;
    logic [AW-1:0]         r_par, n_par, r_p, n_p;
    logic                  r_pdir, n_pdir, r_att_root, n_att_root;
    logic                  r_isadd, n_isadd, r_isq, n_isq;
    logic [31:0]           r_key, n_key;
    logic [32:0]           r_hi, n_hi;
    logic [VALUE_BITS-1:0] r_x, n_x, r_acc, n_acc;
    logic [1:0]            r_side, n_side, r_status, n_status;
    logic [SpBits-1:0]     r_sp, n_sp, r_nnew, n_nnew;

    logic [EW-1:0]         r_stk [StackDepth];
    logic [EW-1:0]         r_stk_q;
    logic                  stk_we, stk_re;
    logic [EW-1:0]         stk_wd;

    t_split                w_sp;
    logic [SpanBits-1:0]   w_end, w_a;
    logic                  w_leaf, w_kleft, w_full;
    logic [NW:0]           w_need;
    logic [AW-1:0]         w_stk_p;
    logic [NW-1:0]         w_stk_sib;
    logic [NW-1:0]         w_next_id;

    // Shared walker arithmetic for the current node [r_l, r_l + r_w).
    assign w_sp      = split_span(r_l, r_w);
    assign w_end     = r_l + r_w;
    assign w_a       = {1'b0, r_key};
    assign w_leaf    = (r_w <= SpanBits'(1));
    assign w_kleft   = (w_a < w_sp.mid);
    assign w_need    = {1'b0, r_used} + (NW+1)'(r_nnew) + (NW+1)'(1);
    assign w_full    = (w_need > (NW+1)'(NODE_COUNT));
    assign w_stk_p   = r_stk_q[EW-1:NW];
    assign w_stk_sib = r_stk_q[NW-1:0];
    assign w_next_id = r_used + NW'(1);

    always_comb begin
        logic end_path;
        end_path   = 1'b0;
        n_state    = r_state;
        n_l        = r_l;
        n_w        = r_w;
        n_save_l   = r_save_l;
        n_save_w   = r_save_w;
        n_pl       = r_pl;
        n_pw       = r_pw;
        n_cur      = r_cur;
        n_used     = r_used;
        n_root     = r_root;
        n_pend     = r_pend;
        n_sib      = r_sib;
        n_par      = r_par;
        n_p        = r_p;
        n_pdir     = r_pdir;
        n_att_root = r_att_root;
        n_isadd    = r_isadd;
        n_isq      = r_isq;
        n_key      = r_key;
        n_hi       = r_hi;
        n_x        = r_x;
        n_acc      = r_acc;
        n_side     = r_side;
        n_status   = r_status;
        n_sp       = r_sp;
        n_nnew     = r_nnew;
        stk_we     = 1'b0;
        stk_re     = 1'b0;
        stk_wd     = {r_cur[AW-1:0], Null};
        o_rd_en    = 1'b0;
        o_rd_addr  = r_cur[AW-1:0];
        o_wr_en    = '0;
        o_wr_addr  = r_cur[AW-1:0];
        o_wr_sum   = r_acc;
        o_wr_left  = Null;
        o_wr_right = Null;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_key    = i_key;
                    n_hi     = i_hi;
                    n_x      = i_x;
                    n_acc    = '0;
                    n_status = StatOk;
                    n_isadd  = (i_func == FuncAdd);
                    n_isq    = (i_func == FuncQuery);
                    n_l      = '0;
                    n_w      = i_dom;
                    n_cur    = r_root;
                    n_sp     = '0;
                    n_side   = SideCommon;
                    n_state  = S_DONE;
                    if (i_dom != '0) begin
                        if (i_func == FuncSet || i_func == FuncAdd) begin
                            if ({1'b0, i_key} >= i_dom) begin
                                n_status = StatRange;
                            end else begin
                                n_state = S_WNODE;
                            end
                        end else if (i_func == FuncQuery) begin
                            if (i_hi > {1'b0, i_key}) begin
                                if (i_hi > i_dom) begin
                                    n_status = StatRange;
                                end else begin
                                    n_state = S_QNODE;
                                end
                            end
                        end
                    end
                end
            end

            // Descend through nodes that already exist.
            S_WNODE: begin
                if (r_cur == Null) begin
                    n_save_l   = r_l;
                    n_save_w   = r_w;
                    n_nnew     = '0;
                    n_att_root = (r_sp == '0);
                    n_state    = S_WCOUNT;
                end else begin
                    o_rd_en = 1'b1;
                    n_state = S_WLINK;
                end
            end

            S_WLINK: begin
                if (w_leaf) begin
                    o_wr_en.sum = 1'b1;
                    o_wr_sum    = r_isadd ? (i_rd_sum + r_x) : r_x;
                    n_acc       = o_wr_sum;
                    n_state     = S_WPOP;
                end else begin
                    stk_we = 1'b1;
                    stk_wd = {r_cur[AW-1:0], w_kleft ? i_rd_right : i_rd_left};
                    n_sp   = r_sp + SpBits'(1);
                    n_par  = r_cur[AW-1:0];
                    n_pdir = w_kleft;
                    if (w_kleft) begin
                        n_cur = i_rd_left;
                        n_w   = w_sp.lo_span;
                    end else begin
                        n_cur = i_rd_right;
                        n_l   = w_sp.mid;
                        n_w   = w_sp.hi_span;
                    end
                    n_state = S_WNODE;
                end
            end

            // Count the missing levels before touching the pool.
            S_WCOUNT: begin
                n_nnew = r_nnew + SpBits'(1);
                if (w_leaf) begin
                    if (w_full) begin
                        n_status = StatFull;
                        n_state  = S_DONE;
                    end else begin
                        n_l     = r_save_l;
                        n_w     = r_save_w;
                        n_state = S_WATTACH;
                    end
                end else if (w_kleft) begin
                    n_w = w_sp.lo_span;
                end else begin
                    n_l = w_sp.mid;
                    n_w = w_sp.hi_span;
                end
            end

            S_WATTACH: begin
                if (r_att_root) begin
                    n_root = r_used;
                end else begin
                    o_wr_addr = r_par;
                    if (r_pdir) begin
                        o_wr_en.left = 1'b1;
                        o_wr_left    = r_used;
                    end else begin
                        o_wr_en.right = 1'b1;
                        o_wr_right    = r_used;
                    end
                end
                n_state = S_WALLOC;
            end

            // Allocate one fresh node per cycle down to the leaf.
            S_WALLOC: begin
                o_wr_en   = '{sum: 1'b1, left: 1'b1, right: 1'b1};
                o_wr_addr = r_used[AW-1:0];
                n_used    = w_next_id;
                if (w_leaf) begin
                    o_wr_sum = r_x;
                    n_acc    = r_x;
                    n_state  = S_WPOP;
                end else begin
                    o_wr_sum = '0;
                    stk_we   = 1'b1;
                    stk_wd   = {r_used[AW-1:0], Null};
                    n_sp     = r_sp + SpBits'(1);
                    if (w_kleft) begin
                        o_wr_left = w_next_id;
                        n_w       = w_sp.lo_span;
                    end else begin
                        o_wr_right = w_next_id;
                        n_l        = w_sp.mid;
                        n_w        = w_sp.hi_span;
                    end
                end
            end

            // Refresh sums on the way back up.
            S_WPOP: begin
                if (r_sp == '0) begin
                    n_state = S_DONE;
                end else begin
                    stk_re  = 1'b1;
                    n_sp    = r_sp - SpBits'(1);
                    n_state = S_WSIB;
                end
            end

            S_WSIB: begin
                if (w_stk_sib == Null) begin
                    o_wr_en.sum = 1'b1;
                    o_wr_addr   = w_stk_p;
                    n_state     = S_WPOP;
                end else begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = w_stk_sib[AW-1:0];
                    n_p       = w_stk_p;
                    n_state   = S_WUP;
                end
            end

            S_WUP: begin
                o_wr_en.sum = 1'b1;
                o_wr_addr   = r_p;
                o_wr_sum    = r_acc + i_rd_sum;
                n_acc       = o_wr_sum;
                n_state     = S_WPOP;
            end

            S_QNODE: begin
                if (r_cur == Null) begin
                    end_path = 1'b1;
                end else begin
                    o_rd_en = 1'b1;
                    n_state = S_QEVAL;
                end
            end

            S_QEVAL: begin
                if (w_a <= r_l && w_end <= r_hi) begin
                    n_acc    = r_acc + i_rd_sum;
                    end_path = 1'b1;
                end else begin
                    n_state = S_QNODE;
                    case (r_side)
                        SideCommon: begin
                            if (r_hi <= w_sp.mid) begin
                                n_cur = i_rd_left;
                                n_w   = w_sp.lo_span;
                            end else if (w_a >= w_sp.mid) begin
                                n_cur = i_rd_right;
                                n_l   = w_sp.mid;
                                n_w   = w_sp.hi_span;
                            end else begin
                                n_pend = i_rd_right;
                                n_pl   = w_sp.mid;
                                n_pw   = w_sp.hi_span;
                                n_side = SideLeft;
                                n_cur  = i_rd_left;
                                n_w    = w_sp.lo_span;
                            end
                        end
                        SideLeft: begin
                            if (w_kleft) begin
                                n_sib   = i_rd_right;
                                n_cur   = i_rd_left;
                                n_w     = w_sp.lo_span;
                                n_state = S_QSIB;
                            end else begin
                                n_cur = i_rd_right;
                                n_l   = w_sp.mid;
                                n_w   = w_sp.hi_span;
                            end
                        end
                        default: begin
                            if (r_hi <= w_sp.mid) begin
                                n_cur = i_rd_left;
                                n_w   = w_sp.lo_span;
                            end else begin
                                n_sib   = i_rd_left;
                                n_cur   = i_rd_right;
                                n_l     = w_sp.mid;
                                n_w     = w_sp.hi_span;
                                n_state = S_QSIB;
                            end
                        end
                    endcase
                end
            end

            // Add the fully covered sibling hanging off a boundary path.
            S_QSIB: begin
                if (r_sib == Null) begin
                    n_state = S_QNODE;
                end else begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = r_sib[AW-1:0];
                    n_state   = S_QSADD;
                end
            end

            S_QSADD: begin
                n_acc   = r_acc + i_rd_sum;
                n_state = S_QNODE;
            end

            S_DONE: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Left boundary finished: continue down the right one; else finish.
        if (end_path) begin
            if (r_side == SideLeft) begin
                n_side  = SideRight;
                n_cur   = r_pend;
                n_l     = r_pl;
                n_w     = r_pw;
                n_state = S_QNODE;
            end else begin
                n_state = S_DONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_root  <= Null;
            r_used  <= '0;
            r_sp    <= '0;
        end else begin
            r_state <= n_state;
            r_root  <= n_root;
            r_used  <= n_used;
            r_sp    <= n_sp;
        end
    end

    always_ff @(posedge i_clk) begin
        r_l        <= n_l;
        r_w        <= n_w;
        r_save_l   <= n_save_l;
        r_save_w   <= n_save_w;
        r_pl       <= n_pl;
        r_pw       <= n_pw;
        r_cur      <= n_cur;
        r_pend     <= n_pend;
        r_sib      <= n_sib;
        r_par      <= n_par;
        r_p        <= n_p;
        r_pdir     <= n_pdir;
        r_att_root <= n_att_root;
        r_isadd    <= n_isadd;
        r_isq      <= n_isq;
        r_key      <= n_key;
        r_hi       <= n_hi;
        r_x        <= n_x;
        r_acc      <= n_acc;
        r_side     <= n_side;
        r_status   <= n_status;
        r_nnew     <= n_nnew;
    end

    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            r_stk[r_sp] <= stk_wd;
        end
        if (stk_re) begin
            r_stk_q <= r_stk[r_sp - SpBits'(1)];
        end
    end

    assign o_idle   = (r_state == S_IDLE);
    assign o_done   = (r_state == S_DONE);
    assign o_result = r_isq ? r_acc : '0;
    assign o_status = r_status;

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= NW'(NODE_COUNT))
        else $error("node pool overrun");

    a_root_alloc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_root == Null) || (r_root <= r_used))
        else $error("root link points past allocated nodes");

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (r_state == S_IDLE))
        else $error("item started while busy");

    a_stack_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= SpBits'(StackDepth))
        else $error("path stack overflow");

endmodule

`default_nettype wire

FILE: hdl/sparse_segment_tree_sum.sv
// ----------------------------------------------------------------------------
// sparse_segment_tree_sum
// Dynamic segment tree over [0, domain_size) with lazily allocated nodes:
// point set, point add and half-open range sum, sums modulo 2^VALUE_BITS.
// ----------------------------------------------------------------------------
// A point write reads and follows each existing level, counts and then
//   allocates each missing level, and on the way up pops the path stack,
//   reads any existing sibling and refreshes each sum before the output stage.
// A query reads each visited node plus each covered sibling on each boundary
//   path; out-of-range items go straight to the done state.
// Items are handled one at a time: a new item is taken only while idle.
// Reset (synchronous, active low) empties the tree and clears domain_size;
//   the node memory itself is not cleared, nodes are written on allocation.
// ----------------------------------------------------------------------------
`default_nettype none

module sparse_segment_tree_sum #(
    parameter int INDEX_BITS = sstsum_pkg::DefIndexBits,
    parameter int NODE_COUNT = sstsum_pkg::DefNodeCount,
    parameter int VALUE_BITS = sstsum_pkg::DefValueBits
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // APB configuration port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready,
    // Input items
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [31:0] index_low, [64:32] index_high, [128:65] operand_value, zero pad
    input  logic [135:0] s_axis_tdata,
    // [1:0] func
    input  logic [1:0]   s_axis_tuser,
    // Result items
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [63:0] result_value
    output logic [63:0]  m_axis_tdata,
    // [1:0] status
    output logic [1:0]   m_axis_tuser
);
    import sstsum_pkg::*;

    localparam int AW = $clog2(NODE_COUNT);
    localparam int NW = $clog2(NODE_COUNT + 1);
    // Largest domain the index width can address.
    localparam logic [33:0] DomLimit = (INDEX_BITS >= 33) ? 34'h1_FFFF_FFFF
                                                          : (34'd1 << INDEX_BITS);

    logic [32:0]           r_dom;
    logic                  w_cfg_wr;
    logic [33:0]           w_wdom;

    logic                  r_out_valid;
    logic [VALUE_BITS-1:0] r_out_result;
    logic [1:0]            r_out_status;

    logic                  w_start, w_take, w_idle, w_done;
    logic [VALUE_BITS-1:0] w_result;
    logic [1:0]            w_status;

    logic                  w_rd_en;
    logic [AW-1:0]         w_rd_addr;
    logic [VALUE_BITS-1:0] w_rd_sum;
    logic [NW-1:0]         w_rd_left, w_rd_right;
    t_wr_en                w_wr_en;
    logic [AW-1:0]         w_wr_addr;
    logic [VALUE_BITS-1:0] w_wr_sum;
    logic [NW-1:0]         w_wr_left, w_wr_right;

    // Configuration: one register at byte address 0, clipped to the domain limit.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr[3] == 1'b0);
    assign w_wdom   = {1'b0, pwdata[32:0]};
    assign prdata   = (paddr[3] == 1'b0) ? {31'd0, r_dom} : 64'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dom <= '0;
        end else if (w_cfg_wr) begin
            r_dom <= (w_wdom > DomLimit) ? DomLimit[32:0] : pwdata[32:0];
        end
    end

    // Take an item only while the sequencer sits idle.
    assign s_axis_tready = w_idle;
    assign w_start       = s_axis_tvalid && w_idle;

    // Output stage: hold a finished item until the sink takes it.
    assign w_take = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done && w_take) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done && w_take) begin
            r_out_result <= w_result;
            r_out_status <= w_status;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = 64'($signed(r_out_result));
    assign m_axis_tuser  = r_out_status;

    sstsum_core #(
        .NODE_COUNT (NODE_COUNT),
        .VALUE_BITS (VALUE_BITS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_func     (s_axis_tuser),
        .i_key      (s_axis_tdata[31:0]),
        .i_hi       (s_axis_tdata[64:32]),
        .i_x        (s_axis_tdata[65 +: VALUE_BITS]),
        .i_dom      (r_dom),
        .i_take     (w_take),
        .o_idle     (w_idle),
        .o_done     (w_done),
        .o_result   (w_result),
        .o_status   (w_status),
        .o_rd_en    (w_rd_en),
        .o_rd_addr  (w_rd_addr),
        .i_rd_sum   (w_rd_sum),
        .i_rd_left  (w_rd_left),
        .i_rd_right (w_rd_right),
        .o_wr_en    (w_wr_en),
        .o_wr_addr  (w_wr_addr),
        .o_wr_sum   (w_wr_sum),
        .o_wr_left  (w_wr_left),
        .o_wr_right (w_wr_right)
    );

    sstsum_mem #(
        .NODE_COUNT (NODE_COUNT),
        .VALUE_BITS (VALUE_BITS)
    ) u_mem (
        .i_clk      (i_clk),
        .i_rd_en    (w_rd_en),
        .i_rd_addr  (w_rd_addr),
        .o_rd_sum   (w_rd_sum),
        .o_rd_left  (w_rd_left),
        .o_rd_right (w_rd_right),
        .i_wr_en    (w_wr_en),
        .i_wr_addr  (w_wr_addr),
        .i_wr_sum   (w_wr_sum),
        .i_wr_left  (w_wr_left),
        .i_wr_right (w_wr_right)
    );

endmodule

`default_nettype wire

FILE: verif/sparse_segment_tree_sum_tb.sv
// ----------------------------------------------------------------------------
// sparse_segment_tree_sum_tb
// Drives point set, point add and range sum items into the sparse segment tree
// under several domain sizes, predicts every result with a local copy of the
// tree and checks each result item in order. Both stream sides idle at random.
// ----------------------------------------------------------------------------
`default_nettype none

module sparse_segment_tree_sum_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sstsum_pkg::*;

    localparam int          Nodes     = 4096;
    localparam int unsigned NullNode  = Nodes;
    localparam int          PathMax   = 34;
    localparam int          DrainWait = 400;
    localparam longint      CycleLimit = 3000000;
    localparam logic [3:0]  AddrDomain = 4'd0;
    localparam logic [1:0]  FuncBad   = 2'd3;
    localparam longint unsigned Full32 = 64'h1_0000_0000;

    typedef struct {
        logic [1:0]  func;
        logic [31:0] lo;
        logic [32:0] hi;
        logic [63:0] val;
    } t_item;

    typedef struct {
        logic [63:0] sum;
        logic [1:0]  status;
    } t_answer;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0]   paddr = '0;
    logic [63:0]  pwdata = '0;
    logic [63:0]  prdata;
    logic         pready;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [135:0] s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [63:0]  m_tdata;
    logic [1:0]   m_tuser;

    sparse_segment_tree_sum u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_axis_tvalid(s_tvalid), .s_axis_tready(s_tready),
        .s_axis_tdata(s_tdata), .s_axis_tuser(s_tuser),
        .m_axis_tvalid(m_tvalid), .m_axis_tready(m_tready),
        .m_axis_tdata(m_tdata), .m_axis_tuser(m_tuser)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Local copy of the tree
    // ------------------------------------------------------------------
    logic [63:0]     tree_sum [Nodes];
    int unsigned     tree_left [Nodes];
    int unsigned     tree_right [Nodes];
    int unsigned     tree_root = NullNode;
    int unsigned     tree_used = 0;
    longint unsigned domain = 0;

    t_answer answer_q[$];
    int      errors = 0;
    int      hold_left = 0;   // long receiver hold-off, counted down by the receiver
    bit      quiet = 1'b0;    // no new random idling on either side while set
    longint  cycles = 0;

    function automatic int unsigned alloc_node();
        int unsigned id;
        id = tree_used;
        tree_used++;
        tree_sum[id] = '0;
        tree_left[id] = NullNode;
        tree_right[id] = NullNode;
        return id;
    endfunction

    function automatic logic [63:0] node_total(int unsigned id);
        return (id < Nodes) ? tree_sum[id] : 64'd0;
    endfunction

    function automatic logic [63:0] span_sum(int unsigned id, longint unsigned a,
                                             longint unsigned b, longint unsigned l,
                                             longint unsigned r);
        longint unsigned m;
        if (id >= Nodes || r <= a || b <= l) return 64'd0;
        if (a <= l && r <= b) return tree_sum[id];
        m = l + ((r - l) >> 1);
        return span_sum(tree_left[id], a, b, l, m) + span_sum(tree_right[id], a, b, m, r);
    endfunction

    function automatic logic [1:0] point_update(longint unsigned k, logic [63:0] x,
                                                bit is_add);
        int unsigned     path [PathMax];
        int unsigned     depth, missing, cur, child;
        longint unsigned l, r, m;
        depth = 0;
        missing = 0;
        // Count the nodes that the path still lacks.
        l = 0;
        r = domain;
        cur = tree_root;
        forever begin
            if (cur >= Nodes) missing++;
            if (r - l <= 1) break;
            m = l + ((r - l) >> 1);
            if (k < m) begin
                if (cur < Nodes) cur = tree_left[cur];
                r = m;
            end else begin
                if (cur < Nodes) cur = tree_right[cur];
                l = m;
            end
        end
        if (tree_used + missing > Nodes) return StatFull;
        l = 0;
        r = domain;
        cur = tree_root;
        if (cur >= Nodes) begin
            cur = alloc_node();
            tree_root = cur;
        end
        path[depth++] = cur;
        while (r - l > 1 && depth < PathMax) begin
            m = l + ((r - l) >> 1);
            if (k < m) begin
                child = tree_left[cur];
                if (child >= Nodes) begin
                    child = alloc_node();
                    tree_left[cur] = child;
                end
                r = m;
            end else begin
                child = tree_right[cur];
                if (child >= Nodes) begin
                    child = alloc_node();
                    tree_right[cur] = child;
                end
                l = m;
            end
            cur = child;
            path[depth++] = cur;
        end
        tree_sum[cur] = is_add ? tree_sum[cur] + x : x;
        for (int i = int'(depth) - 2; i >= 0; i--)
            tree_sum[path[i]] = node_total(tree_left[path[i]]) +
                                node_total(tree_right[path[i]]);
        return StatOk;
    endfunction

    // Apply one accepted item to the local tree and return its answer.
    function automatic t_answer tree_apply(t_item it);
        t_answer a;
        a.sum = '0;
        a.status = StatOk;
        if (domain != 0) begin
            if (it.func == FuncSet || it.func == FuncAdd) begin
                if (it.lo >= domain) a.status = StatRange;
                else a.status = point_update(64'(it.lo), it.val, it.func == FuncAdd);
            end else if (it.func == FuncQuery && it.hi > it.lo) begin
                if (it.hi > domain) a.status = StatRange;
                else a.sum = span_sum(tree_root, 64'(it.lo), 64'(it.hi), 64'd0, domain);
            end
        end
        return a;
    endfunction

    // ------------------------------------------------------------------
    // Checking and receiver idling
    // ------------------------------------------------------------------
    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH %s: got %h want %h at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    int stall_left = 0;
    always @(posedge i_clk) begin
        t_answer w;
        cycles++;
        if (cycles > CycleLimit) begin
            $display("sparse_segment_tree_sum verification failed");
            $finish;
        end
        if (i_rst_n && m_tvalid && m_tready) begin
            if (answer_q.size() == 0) begin
                report("unexpected result", m_tdata, 64'd0);
            end else begin
                w = answer_q.pop_front();
                if (m_tdata !== w.sum) report("result_value", m_tdata, w.sum);
                if (m_tuser !== w.status) report("status", 64'(m_tuser), 64'(w.status));
            end
        end
        // Hold off, stall at random, or take results freely.
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            stall_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 120)
                                                    : $urandom_range(0, 2);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------
    task automatic send_item(t_item it);
        int gap;
        gap = 0;
        if (!quiet) begin
            case ($urandom_range(0, 19))
                0:              gap = $urandom_range(20, 80);
                1, 2, 3, 4, 5:  gap = $urandom_range(1, 3);
                default:        gap = 0;
            endcase
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.func;
        s_tdata  <= {7'd0, it.val, it.hi, it.lo};
        do @(posedge i_clk); while (!s_tready);
        answer_q = {answer_q, tree_apply(it)};
    endtask

    task automatic send(logic [1:0] f, logic [31:0] lo, logic [32:0] hi, logic [63:0] v);
        t_item it;
        it.func = f;
        it.lo = lo;
        it.hi = hi;
        it.val = v;
        send_item(it);
    endtask

    // Drop valid and wait until every result is back and the block is idle.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (answer_q.size() != 0) @(posedge i_clk);
        repeat (DrainWait) @(posedge i_clk);
    endtask

    task automatic set_domain(logic [32:0] v);
        settle();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= AddrDomain;
        pwdata <= {31'd0, v};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        domain = (v > Full32) ? Full32 : v;
    endtask

    function automatic logic [63:0] rand_value();
        case ($urandom_range(0, 3))
            0:       return 64'($urandom_range(0, 100));
            1:       return -64'($urandom_range(0, 100));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Mostly well-formed writes and queries inside the domain, some noise.
    function automatic t_item rand_item();
        t_item           it;
        longint unsigned span;
        int              pick;
        pick = $urandom_range(0, 99);
        it.val = rand_value();
        it.hi = {1'($urandom_range(0, 1)), $urandom};
        it.lo = $urandom;
        if (pick < 45) begin
            it.func = pick[0] ? FuncAdd : FuncSet;
            it.lo = 32'({$urandom} % domain);
        end else if (pick < 85) begin
            it.func = FuncQuery;
            it.lo = 32'({$urandom} % domain);
            span = domain - it.lo;
            it.hi = 33'(it.lo + 1 + ({$urandom} % span));
        end else begin
            it.func = 2'($urandom_range(0, 3));
        end
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        // Disabled domain: everything answers zero.
        send(FuncSet, 32'd0, 33'd0, 64'd5);
        send(FuncAdd, 32'hFFFF_FFFF, 33'd0, 64'd5);
        send(FuncQuery, 32'd0, 33'h1_FFFF_FFFF, 64'd0);
        send(FuncBad, 32'd0, 33'd1, 64'd1);
        // Single-index domain, wrapping add, empty and out-of-domain cases.
        set_domain(33'd1);
        send(FuncSet, 32'd0, 33'd0, 64'hFFFF_FFFF_FFFF_FFFF);
        send(FuncAdd, 32'd0, 33'd0, 64'd1);
        send(FuncAdd, 32'd0, 33'd0, 64'h7FFF_FFFF_FFFF_FFFF);
        send(FuncQuery, 32'd0, 33'd1, 64'd0);
        send(FuncQuery, 32'd0, 33'd2, 64'd0);
        send(FuncQuery, 32'd0, 33'd0, 64'd0);
        send(FuncSet, 32'd1, 33'd0, 64'd3);
        send(FuncBad, 32'd0, 33'd1, 64'd3);
        // Oversized value saturates to the full index range; old nodes persist.
        set_domain(33'h1_FFFF_FFFF);
        send(FuncSet, 32'hFFFF_FFFF, 33'd0, 64'h8000_0000_0000_0000);
        send(FuncAdd, 32'd0, 33'd0, 64'h8000_0000_0000_0000);
        send(FuncQuery, 32'd0, 33'h1_0000_0000, 64'd0);
        send(FuncQuery, 32'hFFFF_FFFF, 33'h1_0000_0000, 64'd0);
        send(FuncQuery, 32'd1, 33'h1_0000_0001, 64'd0);
        send(FuncQuery, 32'hFFFF_FFFF, 33'd5, 64'd0);
        set_domain(33'h1_0000_0000);
        send(FuncQuery, 32'd0, 33'h1_0000_0000, 64'd0);
    endtask

    task automatic test_random_domains();
        logic [32:0] sizes [4] = '{33'd7, 33'd1000, 33'd3, 33'd65536};
        foreach (sizes[i]) begin
            set_domain(sizes[i]);
            quiet = (i == 2);
            repeat (180) send_item(rand_item());
            quiet = 1'b0;
        end
    endtask

    task automatic test_backpressure();
        set_domain(33'd500);
        hold_left = 600;
        quiet = 1'b1;
        repeat (40) send_item(rand_item());
        quiet = 1'b0;
        // Pause the sender until every result has arrived.
        s_tvalid <= 1'b0;
        while (answer_q.size() != 0) @(posedge i_clk);
        repeat (20) send_item(rand_item());
    endtask

    task automatic test_pool_exhaust();
        t_item it;
        set_domain(33'h1_0000_0000);
        repeat (170) begin
            it = rand_item();
            if (it.func != FuncQuery && $urandom_range(0, 3) != 0) begin
                it.func = FuncSet;
                it.lo = $urandom;
            end
            send_item(it);
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_domains();
        test_backpressure();
        test_pool_exhaust();
        settle();
        if (errors == 0) begin
            $display("sparse_segment_tree_sum verification clean");
        end else begin
            $display("sparse_segment_tree_sum verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
hdl/sstsum_pkg.sv
hdl/sstsum_mem.sv
hdl/sstsum_core.sv
hdl/sparse_segment_tree_sum.sv
verif/sparse_segment_tree_sum_tb.sv
